// ===== rtl/dnsd_pkg.sv =====
// Shared types and constants for the DNS name decompressor.
package dnsd_pkg;

  // Position registers cover the largest store plus one label overrun.
  localparam int POS_W = 15;

  localparam logic [7:0] PTR_TAG = 8'hC0;
  localparam logic [7:0] RSV_TAG = 8'h40;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [8:0] USED_MAX = 9'd255;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_PTR  = 2'd1,
    ST_RSV  = 2'd2,
    ST_LONG = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_POS  = 2'd0,
    RD_NEXT = 2'd1,
    RD_COPY = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic       req_type;
    logic [8:0] byte_offset;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] name_chars;
    logic [3:0]  char_count;
    logic        last;
    logic [7:0]  consumed;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic    wr_byte;
    logic    dec_start;
    rd_sel_t rd_sel;
    logic    take_label;
    logic    take_ptr;
    logic    take_term;
    logic    copy_char;
    logic    jump;
    logic    emit_row;
    logic    emit_err;
    status_t err_code;
  } cmd_t;

  typedef struct packed {
    logic pos_oob;
    logic b_zero;
    logic b_ptr;
    logic b_rsv;
    logic lab_long;
    logic lab_oob;
    logic ptr2_oob;
    logic ptr_bad;
    logic term_long;
    logic rem_last;
    logic row_last;
  } sts_t;

endpackage

// ===== rtl/dnsd_ctrl.sv =====
// Decode sequencer: walks labels and pointers, then emits the name rows or an error item.
module dnsd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             req_type,
  input  dnsd_pkg::sts_t   sts,
  output dnsd_pkg::cmd_t   cmd,
  output logic             busy
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FETCH  = 7'b0000010,
    S_TYPE   = 7'b0000100,
    S_COPY   = 7'b0001000,
    S_PTR2   = 7'b0010000,
    S_OUT_RD = 7'b0100000,
    S_OUT_EM = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rd_sel = dnsd_pkg::RD_POS;
    cmd.err_code = dnsd_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req_type == dnsd_pkg::REQ_WRITE) begin
            cmd.wr_byte = 1'b1;
          end else begin
            cmd.dec_start = 1'b1;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (sts.pos_oob) begin
          cmd.emit_err = 1'b1;
          cmd.err_code = dnsd_pkg::ST_PTR;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_sel = dnsd_pkg::RD_POS;
          state_nxt = S_TYPE;
        end
      end
      S_TYPE: begin
        // pointer low byte and first label byte both sit at pos+1
        cmd.rd_sel = dnsd_pkg::RD_NEXT;
        if (sts.b_zero) begin
          if (sts.term_long) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = dnsd_pkg::ST_LONG;
            state_nxt = S_IDLE;
          end else begin
            cmd.take_term = 1'b1;
            state_nxt = S_OUT_RD;
          end
        end else if (sts.b_ptr) begin
          if (sts.ptr2_oob) begin
            cmd.emit_err = 1'b1;
            cmd.err_code = dnsd_pkg::ST_PTR;
            state_nxt = S_IDLE;
          end else begin
            cmd.take_ptr = 1'b1;
            state_nxt = S_PTR2;
          end
        end else if (sts.b_rsv) begin
          cmd.emit_err = 1'b1;
          cmd.err_code = dnsd_pkg::ST_RSV;
          state_nxt = S_IDLE;
        end else if (sts.lab_long) begin
          cmd.emit_err = 1'b1;
          cmd.err_code = dnsd_pkg::ST_LONG;
          state_nxt = S_IDLE;
        end else if (sts.lab_oob) begin
          cmd.emit_err = 1'b1;
          cmd.err_code = dnsd_pkg::ST_PTR;
          state_nxt = S_IDLE;
        end else begin
          cmd.take_label = 1'b1;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_char = 1'b1;
        cmd.rd_sel = dnsd_pkg::RD_COPY;
        if (sts.rem_last) begin
          state_nxt = S_FETCH;
        end
      end
      S_PTR2: begin
        if (sts.ptr_bad) begin
          cmd.emit_err = 1'b1;
          cmd.err_code = dnsd_pkg::ST_PTR;
          state_nxt = S_IDLE;
        end else begin
          cmd.jump = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_EM;
      end
      S_OUT_EM: begin
        cmd.emit_row = 1'b1;
        state_nxt = sts.row_last ? S_IDLE : S_OUT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dnsd_datapath.sv =====
// Message store, name row buffer, walk registers and result register.
module dnsd_datapath #(
  parameter int PKT_BYTES = 512,
  parameter int NAME_MAX  = 255,
  parameter int MAX_HOPS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dnsd_pkg::in_item_t  in_data,
  input  dnsd_pkg::cmd_t      cmd,
  output dnsd_pkg::sts_t      sts,
  output logic                out_strobe,
  output dnsd_pkg::out_item_t out_data
);

  localparam int PW = dnsd_pkg::POS_W;
  localparam int AW = $clog2(PKT_BYTES);
  localparam int NAME_ROWS = (NAME_MAX + 7) / 8;
  localparam int RW = $clog2(NAME_ROWS);
  localparam int HW = $clog2(MAX_HOPS + 2);
  localparam logic [PW-1:0] PKT_LIM = PW'(PKT_BYTES);
  localparam logic [8:0] NAME_LIM = 9'(NAME_MAX);
  localparam logic [HW-1:0] HOP_LIM = HW'(MAX_HOPS);

  logic [7:0]  store_mem [PKT_BYTES];
  logic [63:0] name_mem [NAME_ROWS];

  logic [7:0]    sq_r;
  logic [63:0]   nq_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [8:0]    used_r, used_nxt;
  logic [HW-1:0] hops_r, hops_nxt;
  logic          jumped_r, jumped_nxt;
  logic [5:0]    rem_r, rem_nxt;
  logic [5:0]    hi_r, hi_nxt;
  logic [63:0]   asm_r, asm_nxt;
  logic [RW-1:0] k_r, k_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  dnsd_pkg::out_item_t out_data_r, out_data_nxt;

  logic [PW-1:0] raddr;
  logic [13:0]   tgt;
  logic [8:0]    newlen;
  logic [8:0]    lab_used;
  logic [7:0]    chars_left;
  logic [3:0]    cnt;
  logic [63:0]   row_chars;
  logic          app_en;
  logic [7:0]    app_ch;
  logic [63:0]   asm_ins;
  logic          nw_en;
  logic [63:0]   nw_data;
  logic          st_wr;

  assign tgt = {hi_r, sq_r};
  assign newlen = {1'b0, len_r} + ((len_r != 8'd0) ? 9'd1 : 9'd0) + {3'b000, sq_r[5:0]};
  assign lab_used = used_r + 9'd1 + {3'b000, sq_r[5:0]};
  assign chars_left = len_r - 8'({k_r, 3'b000});

  always_comb begin
    sts.pos_oob   = (pos_r >= PKT_LIM);
    sts.b_zero    = (sq_r == 8'd0);
    sts.b_ptr     = (sq_r >= dnsd_pkg::PTR_TAG);
    sts.b_rsv     = (sq_r >= dnsd_pkg::RSV_TAG);
    sts.lab_long  = (newlen > NAME_LIM) || (!jumped_r && (lab_used > dnsd_pkg::USED_MAX));
    sts.lab_oob   = ((pos_r + PW'(sq_r[5:0])) >= PKT_LIM);
    sts.ptr2_oob  = ((pos_r + PW'(1)) >= PKT_LIM);
    sts.ptr_bad   = (hops_r > HOP_LIM) || (PW'(tgt) >= PKT_LIM);
    sts.term_long = ((used_r + {8'd0, !jumped_r}) > dnsd_pkg::USED_MAX);
    sts.rem_last  = (rem_r == 6'd1);
    sts.row_last  = (len_r == 8'd0) || (chars_left <= 8'd8);
  end

  always_comb begin
    case (cmd.rd_sel)
      dnsd_pkg::RD_POS:  raddr = pos_r;
      dnsd_pkg::RD_NEXT: raddr = pos_r + PW'(1);
      dnsd_pkg::RD_COPY: raddr = rd_r;
      default:           raddr = pos_r;
    endcase
  end

  assign st_wr = cmd.wr_byte && (PW'(in_data.byte_offset) < PKT_LIM);

  always_ff @(posedge clk) begin
    if (st_wr) begin
      store_mem[AW'(in_data.byte_offset)] <= in_data.byte_value;
    end
    sq_r <= store_mem[raddr[AW-1:0]];
  end

  // character append: dot before each label after the first, then label bytes
  assign app_en = (cmd.take_label && (len_r != 8'd0)) || cmd.copy_char;
  assign app_ch = cmd.copy_char ? sq_r : dnsd_pkg::DOT_CHAR;

  always_comb begin
    asm_ins = asm_r;
    asm_ins[{len_r[2:0], 3'b000} +: 8] = app_ch;
  end

  assign nw_en = (app_en && (len_r[2:0] == 3'd7)) ||
                 (cmd.take_term && (len_r[2:0] != 3'd0));
  assign nw_data = cmd.take_term ? asm_r : asm_ins;

  always_ff @(posedge clk) begin
    if (nw_en) begin
      name_mem[len_r[3 +: RW]] <= nw_data;
    end
    nq_r <= name_mem[k_r];
  end

  always_comb begin
    if (len_r == 8'd0) begin
      cnt = 4'd0;
    end else if (chars_left >= 8'd8) begin
      cnt = 4'd8;
    end else begin
      cnt = chars_left[3:0];
    end
  end

  always_comb begin
    row_chars = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < cnt) begin
        row_chars[i*8 +: 8] = nq_r[i*8 +: 8];
      end
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    rd_nxt     = rd_r;
    len_nxt    = len_r;
    used_nxt   = used_r;
    hops_nxt   = hops_r;
    jumped_nxt = jumped_r;
    rem_nxt    = rem_r;
    hi_nxt     = hi_r;
    asm_nxt    = asm_r;
    k_nxt      = k_r;

    if (cmd.dec_start) begin
      pos_nxt    = PW'(in_data.byte_offset);
      len_nxt    = 8'd0;
      used_nxt   = 9'd0;
      hops_nxt   = '0;
      jumped_nxt = 1'b0;
      asm_nxt    = '0;
      k_nxt      = '0;
    end
    if (cmd.take_label) begin
      pos_nxt = pos_r + PW'(1) + PW'(sq_r[5:0]);
      rd_nxt  = pos_r + PW'(2);
      rem_nxt = sq_r[5:0];
      if (!jumped_r) begin
        used_nxt = lab_used;
      end
    end
    if (cmd.take_ptr) begin
      hi_nxt     = sq_r[5:0];
      jumped_nxt = 1'b1;
      hops_nxt   = hops_r + HW'(1);
      if (!jumped_r) begin
        used_nxt = used_r + 9'd2;
      end
    end
    if (cmd.take_term && !jumped_r) begin
      used_nxt = used_r + 9'd1;
    end
    if (cmd.copy_char) begin
      rd_nxt  = rd_r + PW'(1);
      rem_nxt = rem_r - 6'd1;
    end
    if (cmd.jump) begin
      pos_nxt = PW'(tgt);
    end
    if (app_en) begin
      len_nxt = len_r + 8'd1;
      asm_nxt = (len_r[2:0] == 3'd7) ? 64'd0 : asm_ins;
    end
    if (cmd.emit_row) begin
      k_nxt = k_r + RW'(1);
    end
  end

  always_comb begin
    out_strobe_nxt = cmd.emit_row || cmd.emit_err;
    out_data_nxt = out_data_r;
    if (cmd.emit_err) begin
      out_data_nxt.name_chars = '0;
      out_data_nxt.char_count = 4'd0;
      out_data_nxt.last       = 1'b1;
      out_data_nxt.consumed   = 8'd0;
      out_data_nxt.status     = cmd.err_code;
    end else if (cmd.emit_row) begin
      out_data_nxt.name_chars = row_chars;
      out_data_nxt.char_count = cnt;
      out_data_nxt.last       = sts.row_last;
      out_data_nxt.consumed   = used_r[7:0];
      out_data_nxt.status     = dnsd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    rd_r       <= rd_nxt;
    len_r      <= len_nxt;
    used_r     <= used_nxt;
    hops_r     <= hops_nxt;
    jumped_r   <= jumped_nxt;
    rem_r      <= rem_nxt;
    hi_r       <= hi_nxt;
    asm_r      <= asm_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== rtl/dns_name_decompressor.sv =====
// Top level of the DNS name decompressor: sequencer plus datapath.
//
// Input channel: an item is taken at a clock edge with start high and busy low.
// req_type 0 writes byte_value into the message store at byte_offset
// (addresses at or past PKT_BYTES are dropped); busy stays low.
// req_type 1 decodes the name starting at byte_offset. The walk reads the
// single-port message store one byte a cycle: each label length or pointer
// byte takes a fetch and a type state, a pointer's low byte adds a PTR2
// state, and each label character a copy state. Each result row is read
// from the name row buffer, then registered for output.
// An error ends the walk and gives one result the next cycle.
// Results: out_strobe is high for exactly one cycle per item; last marks the
// final item of a decode. The receiver cannot stall; busy drops as the last
// result is registered, so the next item can be taken while it is shown.
// Reset (rst_n low, synchronous) returns the sequencer to idle and clears the
// strobe; the message store is not cleared and must be written before use.
module dns_name_decompressor #(
  parameter int PKT_BYTES = 512,
  parameter int NAME_MAX  = 255,
  parameter int MAX_HOPS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dnsd_pkg::in_item_t  in_data,
  output logic                out_strobe,
  output dnsd_pkg::out_item_t out_data
);

  dnsd_pkg::cmd_t cmd;
  dnsd_pkg::sts_t sts;

  dnsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  dnsd_datapath #(
    .PKT_BYTES (PKT_BYTES),
    .NAME_MAX  (NAME_MAX),
    .MAX_HOPS  (MAX_HOPS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/dnsd_checker.sv =====
// Port-level checks for the DNS name decompressor, bound to the top level.
module dnsd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input dnsd_pkg::in_item_t  in_data,
  input logic                out_strobe,
  input dnsd_pkg::out_item_t out_data
);

  // an error item carries nothing but its code
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status != dnsd_pkg::ST_OK) |->
      (out_data.last && out_data.char_count == 4'd0 &&
       out_data.consumed == 8'd0 && out_data.name_chars == 64'd0))
    else $error("error item not in error form");

  // only the final item of a decode may be short
  a_full_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last) |->
      (out_data.char_count == 4'd8 && out_data.status == dnsd_pkg::ST_OK))
    else $error("non-final item is not a full ok row");

  // more items are due after a non-final one
  a_busy_after_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last) |=> busy)
    else $error("idle with decode items outstanding");

  // a write leaves busy low and makes no result
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.req_type == dnsd_pkg::REQ_WRITE) |=>
      (!busy && !out_strobe))
    else $error("write item caused activity");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.char_count <= 4'd8))
    else $error("char_count above eight");

endmodule

bind dns_name_decompressor dnsd_checker u_dnsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
